### hw/rtl/sse_pkg.sv
// Shared types and constants for the sprite scanline evaluation block.
// No dependencies; imported by every module of the block except sse_cover.
`default_nettype none

package sse_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int ENTRY_BYTES = 4;
  localparam logic [7:0] CLEAR_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    KIND_SET_ADDR = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_EVAL     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } store_wr_t;

  typedef struct packed {
    logic       en;
    logic [1:0] byte_sel;
    logic [7:0] data;
  } list_wr_t;

endpackage

`default_nettype wire

### hw/rtl/sse_store.sv
// Sprite attribute store: 256 x 8 single-port-write RAM with registered read.
// Depends on sse_pkg for the write port struct.
`default_nettype none

module sse_store (
  input  logic               clk,
  input  sse_pkg::store_wr_t wr,
  input  logic [7:0]         rd_addr,
  output logic [7:0]         rd_data
);
  import sse_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/sse_cover.sv
// Range compare: does a sprite starting at row y cover the scanline.
// Depends on nothing; 9-bit unsigned compare so y + height never wraps.
`default_nettype none

module sse_cover #(
  parameter int HEIGHT = 8
) (
  input  logic [7:0] y,
  input  logic [7:0] line,
  output logic       hit
);

  logic [8:0] bottom;

  assign bottom = {1'b0, y} + 9'(HEIGHT);
  assign hit    = (y <= line) && ({1'b0, line} < bottom);

endmodule

`default_nettype wire

### hw/rtl/sse_list.sv
// Secondary sprite list: LIST_SLOTS four-byte slots in flops.
// Depends on sse_pkg for the write struct and fill constant.
`default_nettype none

module sse_list #(
  parameter int LIST_SLOTS = 8,
  parameter int SLOT_W     = 3
) (
  input  logic              clk,
  input  logic              fill,
  input  sse_pkg::list_wr_t wr,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [7:0]        rd_y,
  output logic [7:0]        rd_tile,
  output logic [7:0]        rd_attr,
  output logic [7:0]        rd_x
);
  import sse_pkg::*;

  logic [7:0] slots [LIST_SLOTS][ENTRY_BYTES];

  always_ff @(posedge clk) begin
    if (fill) begin
      for (int s = 0; s < LIST_SLOTS; s++) begin
        for (int b = 0; b < ENTRY_BYTES; b++) begin
          slots[s][b] <= CLEAR_BYTE;
        end
      end
    end else if (wr.en) begin
      slots[wr_slot][wr.byte_sel] <= wr.data;
    end
  end

  assign rd_y    = slots[rd_slot][0];
  assign rd_tile = slots[rd_slot][1];
  assign rd_attr = slots[rd_slot][2];
  assign rd_x    = slots[rd_slot][3];

endmodule

`default_nettype wire

### hw/rtl/sprite_scanline_evaluation_core.sv
// Sprite scanline evaluation core. After reset the 256-byte attribute store
// is swept to zero, one byte a cycle, during which in_ready stays low.
// Set-address and write-byte items are handled without leaving idle. An
// evaluate item fills the secondary list with 0xFF, then scans entries in
// order through the single store read port: a read and a Y compare per
// rejected entry, and for a copied entry the Y compare, then three byte
// reads and writes, stopping when the list fills or the last entry is
// checked. LIST_SLOTS result transfers follow, one per cycle when out_ready
// is high. The registered store read puts a read state before each use.
`default_nettype none

module sprite_scanline_evaluation_core #(
  parameter int SPRITE_ENTRIES = 64,
  parameter int LIST_SLOTS     = 8,
  parameter int SPRITE_HEIGHT  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic [7:0] line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] slot,
  output logic [7:0] sprite_y,
  output logic [7:0] sprite_tile,
  output logic [7:0] sprite_attr,
  output logic [7:0] sprite_x,
  output logic [3:0] found_count,
  output logic       sprite_zero_in_range,
  output logic       last
);
  import sse_pkg::*;

  localparam int ENTRY_W = $clog2(SPRITE_ENTRIES);
  localparam int SLOT_W  = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam int FOUND_W = $clog2(LIST_SLOTS + 1);

  state_t state, state_next;

  logic [7:0]         ptr;
  logic [7:0]         clr_addr;
  logic [7:0]         line_q;
  logic [ENTRY_W-1:0] entry;
  logic [FOUND_W-1:0] found;
  logic [1:0]         byte_sel;
  logic [SLOT_W-1:0]  slot_cnt;
  logic               zero_hit;

  store_wr_t  store_wr;
  list_wr_t   list_wr;
  logic       list_fill;
  logic [7:0] rd_addr;
  logic [7:0] rd_data;
  logic       hit;
  logic       entry_last;
  logic       list_full_next;
  logic       slot_last;
  logic       in_xfer;
  logic       out_xfer;

  sse_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sse_cover #(
    .HEIGHT (SPRITE_HEIGHT)
  ) u_cover (
    .y    (rd_data),
    .line (line_q),
    .hit  (hit)
  );

  sse_list #(
    .LIST_SLOTS (LIST_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_list (
    .clk     (clk),
    .fill    (list_fill),
    .wr      (list_wr),
    .wr_slot (found[SLOT_W-1:0]),
    .rd_slot (slot_cnt),
    .rd_y    (sprite_y),
    .rd_tile (sprite_tile),
    .rd_attr (sprite_attr),
    .rd_x    (sprite_x)
  );

  assign entry_last     = (entry == ENTRY_W'(SPRITE_ENTRIES - 1));
  assign list_full_next = (found == FOUND_W'(LIST_SLOTS - 1));
  assign slot_last      = (slot_cnt == SLOT_W'(LIST_SLOTS - 1));
  assign in_xfer        = in_valid && in_ready;
  assign out_xfer       = out_valid && out_ready;

  assign slot                 = 3'(slot_cnt);
  assign found_count          = 4'(found);
  assign sprite_zero_in_range = zero_hit;
  assign last                 = slot_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    rd_addr    = 8'd0;
    store_wr   = '0;
    list_wr    = '0;
    list_fill  = 1'b0;
    case (state)
      ST_CLEAR: begin
        store_wr.en   = 1'b1;
        store_wr.addr = clr_addr;
        store_wr.data = 8'd0;
        if (clr_addr == 8'hFF) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (kind)
            KIND_WRITE: begin
              store_wr.en   = 1'b1;
              store_wr.addr = ptr;
              store_wr.data = data_byte;
            end
            KIND_EVAL: begin
              list_fill  = 1'b1;
              state_next = ST_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        rd_addr    = 8'({entry, 2'b00});
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        // Y lands in the next free slot whether or not the entry hits
        list_wr.en       = 1'b1;
        list_wr.byte_sel = 2'd0;
        list_wr.data     = rd_data;
        if (hit) begin
          state_next = ST_COPY_RD;
        end else if (entry_last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_COPY_RD: begin
        rd_addr    = 8'({entry, byte_sel});
        state_next = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        list_wr.en       = 1'b1;
        list_wr.byte_sel = byte_sel;
        list_wr.data     = rd_data;
        if (byte_sel == 2'd3) begin
          if (entry_last || list_full_next) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end else begin
          state_next = ST_COPY_RD;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && slot_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= 8'd0;
      clr_addr <= 8'd0;
      entry    <= '0;
      found    <= '0;
      byte_sel <= 2'd0;
      slot_cnt <= '0;
      zero_hit <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + 8'd1;
        ST_IDLE: begin
          if (in_xfer) begin
            case (kind)
              KIND_SET_ADDR: ptr <= data_byte;
              KIND_WRITE:    ptr <= ptr + 8'd1;
              KIND_EVAL: begin
                line_q   <= line;
                entry    <= '0;
                found    <= '0;
                zero_hit <= 1'b0;
                slot_cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN_CMP: begin
          if (entry == '0) begin
            zero_hit <= hit;
          end
          if (hit) begin
            byte_sel <= 2'd1;
          end else begin
            entry <= entry + 1'b1;
          end
        end
        ST_COPY_WR: begin
          if (byte_sel == 2'd3) begin
            found <= found + 1'b1;
            entry <= entry + 1'b1;
          end else begin
            byte_sel <= byte_sel + 2'd1;
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            slot_cnt <= slot_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/sv/sprite_eval_checker.sv
// Checker for the sprite scanline evaluation core: watches both channels, keeps its own
// copy of the attribute store and pointer, and compares every slot result in order.
// Depends on sse_pkg for the kind codes and the store constants.
module sprite_eval_checker #(
  parameter int SPRITE_ENTRIES = 64,
  parameter int LIST_SLOTS     = 8,
  parameter int SPRITE_HEIGHT  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic [7:0] line,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] slot,
  input  logic [7:0] sprite_y,
  input  logic [7:0] sprite_tile,
  input  logic [7:0] sprite_attr,
  input  logic [7:0] sprite_x,
  input  logic [3:0] found_count,
  input  logic       sprite_zero_in_range,
  input  logic       last,
  output int         fails,
  output int         pending
);
  import sse_pkg::*;

  typedef struct packed {
    logic [2:0] slot;
    logic [7:0] y;
    logic [7:0] tile;
    logic [7:0] attr;
    logic [7:0] x;
    logic [3:0] found;
    logic       zero_hit;
    logic       last;
  } slot_rec_t;

  logic [7:0] attr_mem [STORE_DEPTH];
  logic [7:0] wr_ptr;
  slot_rec_t  expected_slots [$];

  function automatic string slot_str(slot_rec_t r);
    return $sformatf("slot %0d y %h tile %h attr %h x %h found %0d zero %b last %b",
                     r.slot, r.y, r.tile, r.attr, r.x, r.found, r.zero_hit, r.last);
  endfunction

  // Secondary list build for one scanline, then one expected result per slot.
  task automatic predict_scanline(input logic [7:0] ln);
    logic [7:0] list_bytes [LIST_SLOTS*ENTRY_BYTES];
    logic [7:0] y;
    logic       hit;
    logic       zero_hit;
    int         found;
    int         base;
    slot_rec_t  rec;
    for (int i = 0; i < LIST_SLOTS*ENTRY_BYTES; i++) list_bytes[i] = CLEAR_BYTE;
    found    = 0;
    zero_hit = 1'b0;
    for (int e = 0; e < SPRITE_ENTRIES && e < STORE_DEPTH/ENTRY_BYTES; e++) begin
      if (found >= LIST_SLOTS) break;
      base = e*ENTRY_BYTES;
      y    = attr_mem[base];
      // 9-bit range check, no wrap near 255
      hit  = (int'(y) <= int'(ln)) && (int'(ln) < int'(y) + SPRITE_HEIGHT);
      if (e == 0) zero_hit = hit;
      // rejected entries still leave their Y in the next free slot
      list_bytes[found*ENTRY_BYTES] = y;
      if (hit) begin
        for (int b = 1; b < ENTRY_BYTES; b++) list_bytes[found*ENTRY_BYTES+b] = attr_mem[base+b];
        found++;
      end
    end
    for (int s = 0; s < LIST_SLOTS; s++) begin
      rec.slot     = 3'(s);
      rec.y        = list_bytes[s*ENTRY_BYTES];
      rec.tile     = list_bytes[s*ENTRY_BYTES+1];
      rec.attr     = list_bytes[s*ENTRY_BYTES+2];
      rec.x        = list_bytes[s*ENTRY_BYTES+3];
      rec.found    = 4'(found);
      rec.zero_hit = zero_hit;
      rec.last     = (s == LIST_SLOTS-1);
      expected_slots.push_back(rec);
    end
  endtask

  always @(posedge clk) begin
    slot_rec_t got;
    slot_rec_t want;
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) attr_mem[i] = 8'h00;
      wr_ptr = 8'h00;
      expected_slots.delete();
    end else begin
      // result side first: a result can never belong to an item taken at this edge
      if (out_valid && out_ready) begin
        got = {slot, sprite_y, sprite_tile, sprite_attr, sprite_x, found_count,
               sprite_zero_in_range, last};
        if (expected_slots.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: %s", slot_str(got));
        end else begin
          want = expected_slots.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch exp: %s", slot_str(want));
              $display("         got: %s", slot_str(got));
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        case (kind)
          KIND_SET_ADDR: wr_ptr = data_byte;
          KIND_WRITE: begin
            attr_mem[wr_ptr] = data_byte;
            wr_ptr = wr_ptr + 8'd1;
          end
          KIND_EVAL: predict_scanline(line);
          default: ;
        endcase
      end
    end
    pending = expected_slots.size();
  end

endmodule

### tb/sv/tb_top.sv
// Top of the sprite scanline evaluation testbench: clock, reset, stimulus, receiver
// back-pressure and the verdict. Needs sse_pkg, the core and sprite_eval_checker.
module tb_top;
  import sse_pkg::*;

  localparam int SPRITE_ENTRIES = 64;
  localparam int LIST_SLOTS     = 8;
  localparam int SPRITE_HEIGHT  = 8;
  localparam int RANDOM_OPS     = 240;
  localparam int HOLD_CYCLES    = 800;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = KIND_SET_ADDR;
  logic [7:0] data_byte = 8'h00;
  logic [7:0] line = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] slot;
  logic [7:0] sprite_y;
  logic [7:0] sprite_tile;
  logic [7:0] sprite_attr;
  logic [7:0] sprite_x;
  logic [3:0] found_count;
  logic       sprite_zero_in_range;
  logic       last;
  int         fails;
  int         pending;

  logic       no_idle  = 1'b0;
  logic       hold_req = 1'b0;
  int         ops_sent = 0;

  always #5 clk = ~clk;

  sprite_scanline_evaluation_core #(
    .SPRITE_ENTRIES(SPRITE_ENTRIES),
    .LIST_SLOTS(LIST_SLOTS),
    .SPRITE_HEIGHT(SPRITE_HEIGHT)
  ) dut (.*);

  sprite_eval_checker #(
    .SPRITE_ENTRIES(SPRITE_ENTRIES),
    .LIST_SLOTS(LIST_SLOTS),
    .SPRITE_HEIGHT(SPRITE_HEIGHT)
  ) chk (.*);

  // one input transfer, with random idle cycles ahead of it
  task automatic sprite_op(input logic [1:0] op, input logic [7:0] arg, input logic [7:0] ln);
    while (!no_idle && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= op;
    data_byte <= arg;
    line      <= ln;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != KIND_UNUSED) ops_sent++;
  endtask

  // Y plus random tile, attribute and X at the current pointer
  task automatic write_entry(input logic [7:0] y);
    sprite_op(KIND_WRITE, y, 8'($urandom));
    repeat (3) sprite_op(KIND_WRITE, 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] near_y(input logic [7:0] tgt);
    return tgt - 8'($urandom_range(0, 9));
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  initial begin
    logic [7:0] tgt;
    int         pick;
    int         n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // store is all zeros: lines 0..7 fill the list from the first entries
    sprite_op(KIND_EVAL, 8'h00, 8'd0);
    sprite_op(KIND_EVAL, 8'hFF, 8'd7);
    sprite_op(KIND_EVAL, 8'h00, 8'd8);
    // entry 0 at Y=255: covers line 255 only, no wrap back to 0
    sprite_op(KIND_SET_ADDR, 8'd0, 8'h00);
    sprite_op(KIND_WRITE, 8'hFF, 8'h00);
    sprite_op(KIND_WRITE, 8'h00, 8'h00);
    sprite_op(KIND_WRITE, 8'h80, 8'h00);
    sprite_op(KIND_WRITE, 8'hFF, 8'h00);
    sprite_op(KIND_EVAL, 8'h00, 8'd255);
    sprite_op(KIND_EVAL, 8'h00, 8'd0);
    // pointer wraps from 255 to 0
    sprite_op(KIND_SET_ADDR, 8'd255, 8'h00);
    sprite_op(KIND_WRITE, 8'h12, 8'h00);
    sprite_op(KIND_WRITE, 8'h34, 8'h00);
    sprite_op(KIND_UNUSED, 8'hFF, 8'hFF);
    sprite_op(KIND_EVAL, 8'h00, 8'h34);
    // last entry in range, found at the very end of the scan
    sprite_op(KIND_SET_ADDR, 8'd252, 8'h00);
    sprite_op(KIND_WRITE, 8'hF0, 8'h00);
    sprite_op(KIND_WRITE, 8'hAB, 8'h00);
    sprite_op(KIND_WRITE, 8'h3C, 8'h00);
    sprite_op(KIND_WRITE, 8'hC3, 8'h00);
    sprite_op(KIND_EVAL, 8'h00, 8'd247);
    sprite_op(KIND_EVAL, 8'h00, 8'd248);
    sprite_op(KIND_EVAL, 8'h00, 8'd239);

    // receiver stalls for a long while as the sender keeps offering
    hold_req = 1'b1;
    ops_sent = 0;
    while (ops_sent < RANDOM_OPS) begin
      no_idle = (ops_sent >= 120 && ops_sent < 190);
      pick = $urandom_range(0, 99);
      tgt  = 8'($urandom);
      if (pick < 55) begin
        // a few sprites placed around one line, then that line evaluated
        n = $urandom_range(1, 4);
        repeat (n) begin
          sprite_op(KIND_SET_ADDR, 8'($urandom_range(0, 63) * ENTRY_BYTES), 8'($urandom));
          write_entry(near_y(tgt));
        end
        sprite_op(KIND_EVAL, 8'($urandom), tgt);
      end else if (pick < 63) begin
        // crowded line: up to twelve neighbors, which can fill the list mid-scan
        sprite_op(KIND_SET_ADDR, 8'($urandom_range(0, 56) * ENTRY_BYTES), 8'($urandom));
        n = $urandom_range(6, 12);
        repeat (n) write_entry(near_y(tgt));
        sprite_op(KIND_EVAL, 8'($urandom), tgt);
      end else if (pick < 85) begin
        sprite_op(KIND_EVAL, 8'($urandom), tgt);
      end else begin
        sprite_op(2'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    no_idle  = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
